FILE: design/gsm_pkg.sv
// Shared types and constants for the sparse GF(2) matrix-vector engine.
package gsm_pkg;

  typedef enum logic [2:0] {
    MODE_COL_PTR  = 3'd0,
    MODE_ROW_ENT  = 3'd1,
    MODE_VEC_BIT  = 3'd2,
    MODE_MULTIPLY = 3'd3,
    MODE_FORWARD  = 3'd4,
    MODE_BACKWARD = 3'd5,
    MODE_RD_PROD  = 3'd6,
    MODE_RD_VEC   = 3'd7
  } mode_e;

  localparam logic CFG_NUM_COLS = 1'b0;
  localparam logic CFG_NUM_ROWS = 1'b1;

  typedef struct packed {
    mode_e       mode;
    logic [14:0] address;
    logic [15:0] entry;
    logic        bit_in;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEC_WR,
    ST_RD_PROD,
    ST_RD_VEC,
    ST_COL,
    ST_COL_WAIT,
    ST_PTR_WAIT,
    ST_ENT,
    ST_ENT_WAIT,
    ST_TGT_WAIT
  } state_e;

endpackage

FILE: design/gsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/gsm_front.sv
// Front end: accepts items into a two-entry queue toward the execution unit.
module gsm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  gsm_pkg::item_t item_i,
  output logic          busy_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output gsm_pkg::item_t head_o
);

  gsm_pkg::item_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q, count_d;
  logic       push;

  assign busy_o       = (count_q == 2'd2);
  assign push         = start_i && !busy_o;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !(pop_i && head_valid_o)) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i && head_valid_o) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i && head_valid_o) begin
        rptr_q <= !rptr_q;
      end
    end
  end

endmodule

FILE: design/gsm_back.sv
// Execution unit: loads the stores, walks columns for runs and returns results.
module gsm_back #(
  parameter int MAX_COLS     = 8192,
  parameter int MAX_ROWS     = 8192,
  parameter int MAX_NONZEROS = 32768
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [13:0]    num_cols_i,
  input  logic [13:0]    num_rows_i,
  input  logic           head_valid_i,
  input  gsm_pkg::item_t head_i,
  output logic           pop_o,
  output logic           result_valid_o,
  output logic [63:0]    result_word_o,
  output logic           run_done_o,
  output logic           range_error_o
);

  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int LW  = $clog2(MAX_ROWS + 1) > CW ? $clog2(MAX_ROWS + 1) : CW;
  localparam int SWD = (MAX_COLS + 63) / 64;
  localparam int RWD = (MAX_ROWS + 63) / 64;
  localparam int SW  = (SWD > 1) ? $clog2(SWD) : 1;
  localparam int RW  = (RWD > 1) ? $clog2(RWD) : 1;
  localparam int NW  = $clog2(MAX_NONZEROS);

  gsm_pkg::state_e state_q, state_d;
  gsm_pkg::item_t  cur_q, cur_d;
  logic [CW-1:0]   c_q, c_d, rem_q, rem_d;
  logic [15:0]     k_q, k_d, end_q, end_d, r_q, r_d;
  logic            err_q, err_d;
  logic [RWD-1:0]  pv_q, pv_d;
  logic            rv_q, rv_d, rd_q, rd_d, re_q, re_d;
  logic [63:0]     rw_q, rw_d;

  logic [CW-1:0]   cols_use;
  logic [LW-1:0]   rows_use, limit;
  logic            is_mul;

  logic            cs_we;
  logic [CW-1:0]   cs_waddr, cs_raddr;
  logic [15:0]     cs_rdata;
  logic            re_we;
  logic [NW-1:0]   re_waddr, re_raddr;
  logic [15:0]     re_rdata;
  logic            src_we;
  logic [SW-1:0]   src_waddr, src_raddr;
  logic [63:0]     src_wdata, src_rdata;
  logic            prd_we;
  logic [RW-1:0]   prd_waddr, prd_raddr;
  logic [63:0]     prd_wdata, prd_rdata, prd_cur;

  assign cols_use = (32'(num_cols_i) > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(num_cols_i);
  assign rows_use = (32'(num_rows_i) > 32'(MAX_ROWS)) ? LW'(MAX_ROWS) : LW'(num_rows_i);
  assign is_mul   = (cur_q.mode == gsm_pkg::MODE_MULTIPLY);
  assign limit    = is_mul ? rows_use : LW'(cols_use);
  assign prd_cur  = pv_q[prd_waddr] ? prd_rdata : 64'd0;

  gsm_ram #(.WIDTH(16), .DEPTH(MAX_COLS + 1), .AW(CW)) u_col_start (
    .clk_i, .we_i(cs_we), .waddr_i(cs_waddr), .wdata_i(head_i.entry),
    .raddr_i(cs_raddr), .rdata_o(cs_rdata)
  );
  gsm_ram #(.WIDTH(16), .DEPTH(MAX_NONZEROS), .AW(NW)) u_row_entry (
    .clk_i, .we_i(re_we), .waddr_i(re_waddr), .wdata_i(head_i.entry),
    .raddr_i(re_raddr), .rdata_o(re_rdata)
  );
  gsm_ram #(.WIDTH(64), .DEPTH(SWD), .AW(SW)) u_source (
    .clk_i, .we_i(src_we), .waddr_i(src_waddr), .wdata_i(src_wdata),
    .raddr_i(src_raddr), .rdata_o(src_rdata)
  );
  gsm_ram #(.WIDTH(64), .DEPTH(RWD), .AW(RW)) u_product (
    .clk_i, .we_i(prd_we), .waddr_i(prd_waddr), .wdata_i(prd_wdata),
    .raddr_i(prd_raddr), .rdata_o(prd_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    c_d       = c_q;
    rem_d     = rem_q;
    k_d       = k_q;
    end_d     = end_q;
    r_d       = r_q;
    err_d     = err_q;
    pv_d      = pv_q;
    rv_d      = 1'b0;
    rd_d      = 1'b0;
    re_d      = 1'b0;
    rw_d      = 64'd0;
    pop_o     = 1'b0;
    cs_we     = 1'b0;
    cs_waddr  = CW'(head_i.address);
    cs_raddr  = c_q;
    re_we     = 1'b0;
    re_waddr  = NW'(head_i.address);
    re_raddr  = NW'(k_q);
    src_we    = 1'b0;
    src_waddr = SW'(r_q >> 6);
    src_wdata = src_rdata ^ (64'd1 << r_q[5:0]);
    src_raddr = SW'(c_q >> 6);
    prd_we    = 1'b0;
    prd_waddr = RW'(r_q >> 6);
    prd_wdata = prd_cur ^ (64'd1 << r_q[5:0]);
    prd_raddr = RW'(head_i.address);
    case (state_q)
      gsm_pkg::ST_IDLE: begin
        if (head_valid_i) begin
          pop_o     = 1'b1;
          cur_d     = head_i;
          src_raddr = SW'(head_i.address);
          c_d       = '0;
          rem_d     = cols_use;
          err_d     = 1'b0;
          case (head_i.mode)
            gsm_pkg::MODE_COL_PTR: begin
              cs_we = (32'(head_i.address) <= 32'(MAX_COLS));
            end
            gsm_pkg::MODE_ROW_ENT: begin
              re_we = (32'(head_i.address) < 32'(MAX_NONZEROS));
            end
            gsm_pkg::MODE_VEC_BIT: begin
              src_raddr = SW'(head_i.address >> 6);
              if (32'(head_i.address) < 32'(MAX_COLS)) begin
                state_d = gsm_pkg::ST_VEC_WR;
              end
            end
            gsm_pkg::MODE_MULTIPLY: begin
              pv_d    = '0;
              state_d = gsm_pkg::ST_COL;
            end
            gsm_pkg::MODE_FORWARD: begin
              state_d = gsm_pkg::ST_COL;
            end
            gsm_pkg::MODE_BACKWARD: begin
              c_d     = cols_use - 1'b1;
              state_d = gsm_pkg::ST_COL;
            end
            gsm_pkg::MODE_RD_PROD: begin
              state_d = gsm_pkg::ST_RD_PROD;
            end
            default: begin
              state_d = gsm_pkg::ST_RD_VEC;
            end
          endcase
        end
      end
      gsm_pkg::ST_VEC_WR: begin
        src_we    = 1'b1;
        src_waddr = SW'(cur_q.address >> 6);
        src_wdata = src_rdata;
        src_wdata[cur_q.address[5:0]] = cur_q.bit_in;
        state_d   = gsm_pkg::ST_IDLE;
      end
      gsm_pkg::ST_RD_PROD: begin
        rv_d = 1'b1;
        if (32'(cur_q.address) < 32'(RWD) && pv_q[RW'(cur_q.address)]) begin
          rw_d = prd_rdata;
        end
        state_d = gsm_pkg::ST_IDLE;
      end
      gsm_pkg::ST_RD_VEC: begin
        rv_d = 1'b1;
        if (32'(cur_q.address) < 32'(SWD)) begin
          rw_d = src_rdata;
        end
        state_d = gsm_pkg::ST_IDLE;
      end
      gsm_pkg::ST_COL: begin
        if (rem_q == '0) begin
          rv_d    = 1'b1;
          rd_d    = 1'b1;
          re_d    = err_q;
          state_d = gsm_pkg::ST_IDLE;
        end else begin
          state_d = gsm_pkg::ST_COL_WAIT;
        end
      end
      gsm_pkg::ST_COL_WAIT: begin
        cs_raddr = c_q + 1'b1;
        k_d      = cs_rdata;
        state_d  = gsm_pkg::ST_PTR_WAIT;
        if (!src_rdata[c_q[5:0]]) begin
          rem_d   = rem_q - 1'b1;
          c_d     = (cur_q.mode == gsm_pkg::MODE_BACKWARD) ? c_q - 1'b1 : c_q + 1'b1;
          state_d = gsm_pkg::ST_COL;
        end
      end
      gsm_pkg::ST_PTR_WAIT: begin
        end_d   = cs_rdata;
        state_d = gsm_pkg::ST_ENT;
      end
      gsm_pkg::ST_ENT: begin
        if (k_q >= end_q) begin
          rem_d   = rem_q - 1'b1;
          c_d     = (cur_q.mode == gsm_pkg::MODE_BACKWARD) ? c_q - 1'b1 : c_q + 1'b1;
          state_d = gsm_pkg::ST_COL;
        end else if (32'(k_q) >= 32'(MAX_NONZEROS)) begin
          err_d = 1'b1;
          k_d   = k_q + 16'd1;
        end else begin
          state_d = gsm_pkg::ST_ENT_WAIT;
        end
      end
      gsm_pkg::ST_ENT_WAIT: begin
        r_d       = re_rdata;
        src_raddr = SW'(re_rdata >> 6);
        prd_raddr = RW'(re_rdata >> 6);
        if (LW'(32'(re_rdata)) >= limit || 32'(re_rdata) >= 32'(limit)) begin
          err_d   = 1'b1;
          k_d     = k_q + 16'd1;
          state_d = gsm_pkg::ST_ENT;
        end else begin
          state_d = gsm_pkg::ST_TGT_WAIT;
        end
      end
      gsm_pkg::ST_TGT_WAIT: begin
        if (is_mul) begin
          prd_we          = 1'b1;
          pv_d[prd_waddr] = 1'b1;
        end else begin
          src_we = 1'b1;
        end
        k_d     = k_q + 16'd1;
        state_d = gsm_pkg::ST_ENT;
      end
      default: begin
        state_d = gsm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    c_q    <= c_d;
    rem_q  <= rem_d;
    k_q    <= k_d;
    end_q  <= end_d;
    r_q    <= r_d;
    err_q  <= err_d;
    rw_q   <= rw_d;
    rd_q   <= rd_d;
    re_q   <= re_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsm_pkg::ST_IDLE;
      pv_q    <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
      rv_q    <= rv_d;
    end
  end

  assign result_valid_o = rv_q;
  assign result_word_o  = rw_q;
  assign run_done_o     = rd_q;
  assign range_error_o  = re_q;

endmodule

FILE: design/gf2_sparse_matvec_substitution.sv
// Top level of the sparse GF(2) matrix-vector multiply and substitution engine.
// Items enter through a two-entry queue; busy_o is high only while that queue is full.
// Pointer and row-entry writes go straight to their RAMs and vector writes read, modify
// and write back a word. A word read's result is strobed on result_valid_o for one cycle;
// the receiver cannot stall. A run walks serially through the column, entry and vector
// RAMs, visiting every column in use and every nonzero entry of each set column.
module gf2_sparse_matvec_substitution #(
  parameter int MAX_COLS     = 8192,
  parameter int MAX_ROWS     = 8192,
  parameter int MAX_NONZEROS = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [13:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  mode_i,
  input  logic [14:0] address_i,
  input  logic [15:0] entry_i,
  input  logic        bit_in_i,
  output logic        result_valid_o,
  output logic [63:0] result_word_o,
  output logic        run_done_o,
  output logic        range_error_o
);

  logic [13:0]    num_cols_q, num_rows_q;
  gsm_pkg::item_t item, head;
  logic           head_valid, pop;

  assign item.mode    = gsm_pkg::mode_e'(mode_i);
  assign item.address = address_i;
  assign item.entry   = entry_i;
  assign item.bit_in  = bit_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= 14'd1;
      num_rows_q <= 14'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == gsm_pkg::CFG_NUM_COLS) begin
        num_cols_q <= cfg_data_i;
      end else begin
        num_rows_q <= cfg_data_i;
      end
    end
  end

  gsm_front u_front (
    .clk_i, .rst_ni, .start_i, .item_i(item), .busy_o,
    .pop_i(pop), .head_valid_o(head_valid), .head_o(head)
  );

  gsm_back #(
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .MAX_NONZEROS(MAX_NONZEROS)
  ) u_back (
    .clk_i, .rst_ni, .num_cols_i(num_cols_q), .num_rows_i(num_rows_q),
    .head_valid_i(head_valid), .head_i(head), .pop_o(pop),
    .result_valid_o, .result_word_o, .run_done_o, .range_error_o
  );

endmodule
